>>> src/segment_intersection_point_top_assert.svh
// Assertion macros for the segment intersection block.
// Used by sip_props; expects signals named clock and reset in scope.
`ifndef SEGMENT_INTERSECTION_POINT_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_TOP_ASSERT_SVH

// Same-cycle implication, off during reset
`define SIP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define SIP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset
`define SIP_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sip_pkg.sv
// Shared widths, constants and item types for the segment intersection block.
// No dependencies; imported by every module of the block.
package sip_pkg;

   // Coordinate format: signed Q12.4
   localparam int COORD_W = 16;
   localparam int FRAC_W  = 4;

   // Derived arithmetic widths
   localparam int DIFF_W  = COORD_W + 1;        // coordinate difference
   localparam int PROD_W  = 2 * DIFF_W;         // product of two differences
   localparam int CROSS_W = PROD_W + 1;         // cross product
   localparam int DEN_W   = CROSS_W + 1;        // d1 + d2
   localparam int DMAG_W  = COORD_W;            // |P2 - P1| per axis
   localparam int NUM_W   = DMAG_W + CROSS_W;   // |delta| * d1
   localparam int QUO_W   = COORD_W;            // quotient, below |delta|

   // Pipeline geometry
   localparam int FRONT_STAGES  = 5;
   localparam int DIV_STAGES    = QUO_W;
   localparam int PIPE_CAPACITY = FRONT_STAGES + DIV_STAGES + 2;
   localparam int INFLIGHT_W    = $clog2(PIPE_CAPACITY + 1) + 1;

   // Stream widths
   localparam int REQ_DATA_W = 8 * COORD_W;
   localparam int RSP_DATA_W = 2 * COORD_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic        [CROSS_W-1:0] mag_type;
   typedef logic        [DEN_W-1:0]   den_type;
   typedef logic        [DMAG_W-1:0]  dmag_type;
   typedef logic        [NUM_W-1:0]   num_type;
   typedef logic        [QUO_W-1:0]   quo_type;

   // Point reported when the segments do not cross: (-100.0, -100.0)
   localparam coord_type SENTINEL = COORD_W'(-(100 * (2 ** FRAC_W)));

   // One input item: two segments
   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_end_x;
      coord_type second_end_y;
   } seg_pair_type;

   // Front end to divider
   typedef struct packed {
      logic      hit;
      logic      neg_x;
      logic      neg_y;
      coord_type start_x;
      coord_type start_y;
      den_type   den;
      num_type   num_x;
      num_type   num_y;
   } div_in_type;

   // Divider to output stage
   typedef struct packed {
      logic      hit;
      logic      neg_x;
      logic      neg_y;
      coord_type start_x;
      coord_type start_y;
      quo_type   quo_x;
      quo_type   quo_y;
   } div_out_type;

   // One result item
   typedef struct packed {
      logic      crossed;
      coord_type cross_x;
      coord_type cross_y;
   } result_type;

endpackage

>>> src/sip_front.sv
// Front end: differences, cross products, sides test and divider operands.
// Five register stages; depends on sip_pkg.
module sip_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sip_pkg::seg_pair_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sip_pkg::div_in_type   out_item
);
   import sip_pkg::*;

   typedef struct packed {
      diff_type  px, py, vx, vy;
      diff_type  e1x, e1y, e2x, e2y;
      diff_type  f1x, f1y, f2x, f2y;
      coord_type ax, ay;
   } st1_type;

   typedef struct packed {
      prod_type  m1a, m1b, m2a, m2b, m3a, m3b, m4a, m4b;
      diff_type  px, py;
      coord_type ax, ay;
   } st2_type;

   typedef struct packed {
      cross_type s1, s2, s3, s4;
      diff_type  px, py;
      coord_type ax, ay;
   } st3_type;

   typedef struct packed {
      logic      hit;
      mag_type   d1, d2;
      dmag_type  mag_x, mag_y;
      logic      neg_x, neg_y;
      coord_type ax, ay;
   } st4_type;

   st1_type    st1_ff, st1_in;
   st2_type    st2_ff, st2_in;
   st3_type    st3_ff, st3_in;
   st4_type    st4_ff, st4_in;
   div_in_type st5_ff, st5_in;
   logic [FRONT_STAGES-1:0] vld_ff, vld_in;
   logic       adv;

   // Whole front end moves together unless its last item is held
   assign adv       = !vld_ff[FRONT_STAGES-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_item  = st5_ff;
   assign vld_in    = {vld_ff[FRONT_STAGES-2:0], in_valid};

   // Stage 1: coordinate differences
   always_comb begin
      st1_in.px  = diff_type'(in_item.first_end_x) - diff_type'(in_item.first_start_x);
      st1_in.py  = diff_type'(in_item.first_end_y) - diff_type'(in_item.first_start_y);
      st1_in.vx  = diff_type'(in_item.second_end_x) - diff_type'(in_item.second_start_x);
      st1_in.vy  = diff_type'(in_item.second_end_y) - diff_type'(in_item.second_start_y);
      st1_in.e1x = diff_type'(in_item.second_start_x) - diff_type'(in_item.first_start_x);
      st1_in.e1y = diff_type'(in_item.second_start_y) - diff_type'(in_item.first_start_y);
      st1_in.e2x = diff_type'(in_item.second_end_x) - diff_type'(in_item.first_start_x);
      st1_in.e2y = diff_type'(in_item.second_end_y) - diff_type'(in_item.first_start_y);
      st1_in.f1x = diff_type'(in_item.first_start_x) - diff_type'(in_item.second_start_x);
      st1_in.f1y = diff_type'(in_item.first_start_y) - diff_type'(in_item.second_start_y);
      st1_in.f2x = diff_type'(in_item.first_end_x) - diff_type'(in_item.second_start_x);
      st1_in.f2y = diff_type'(in_item.first_end_y) - diff_type'(in_item.second_start_y);
      st1_in.ax  = in_item.first_start_x;
      st1_in.ay  = in_item.first_start_y;
   end

   // Stage 2: the eight partial products of the four cross products
   always_comb begin
      st2_in.m1a = prod_type'(st1_ff.e1x) * prod_type'(st1_ff.py);
      st2_in.m1b = prod_type'(st1_ff.e1y) * prod_type'(st1_ff.px);
      st2_in.m2a = prod_type'(st1_ff.e2x) * prod_type'(st1_ff.py);
      st2_in.m2b = prod_type'(st1_ff.e2y) * prod_type'(st1_ff.px);
      st2_in.m3a = prod_type'(st1_ff.vx) * prod_type'(st1_ff.f1y);
      st2_in.m3b = prod_type'(st1_ff.vy) * prod_type'(st1_ff.f1x);
      st2_in.m4a = prod_type'(st1_ff.vx) * prod_type'(st1_ff.f2y);
      st2_in.m4b = prod_type'(st1_ff.vy) * prod_type'(st1_ff.f2x);
      st2_in.px  = st1_ff.px;
      st2_in.py  = st1_ff.py;
      st2_in.ax  = st1_ff.ax;
      st2_in.ay  = st1_ff.ay;
   end

   // Stage 3: cross products
   always_comb begin
      st3_in.s1 = cross_type'(st2_ff.m1a) - cross_type'(st2_ff.m1b);
      st3_in.s2 = cross_type'(st2_ff.m2a) - cross_type'(st2_ff.m2b);
      st3_in.s3 = cross_type'(st2_ff.m3a) - cross_type'(st2_ff.m3b);
      st3_in.s4 = cross_type'(st2_ff.m4a) - cross_type'(st2_ff.m4b);
      st3_in.px = st2_ff.px;
      st3_in.py = st2_ff.py;
      st3_in.ax = st2_ff.ax;
      st3_in.ay = st2_ff.ay;
   end

   // Stage 4: strict sides test and magnitudes
   always_comb begin
      logic sides_first, sides_second;
      cross_type abs3, abs4;
      diff_type  abs_px, abs_py;
      sides_first  = (st3_ff.s1 != '0) && (st3_ff.s2 != '0)
                     && (st3_ff.s1[CROSS_W-1] != st3_ff.s2[CROSS_W-1]);
      sides_second = (st3_ff.s3 != '0) && (st3_ff.s4 != '0)
                     && (st3_ff.s3[CROSS_W-1] != st3_ff.s4[CROSS_W-1]);
      abs3   = st3_ff.s3[CROSS_W-1] ? -st3_ff.s3 : st3_ff.s3;
      abs4   = st3_ff.s4[CROSS_W-1] ? -st3_ff.s4 : st3_ff.s4;
      abs_px = st3_ff.px[DIFF_W-1] ? -st3_ff.px : st3_ff.px;
      abs_py = st3_ff.py[DIFF_W-1] ? -st3_ff.py : st3_ff.py;
      st4_in.hit   = sides_first && sides_second;
      st4_in.d1    = mag_type'(abs3);
      st4_in.d2    = mag_type'(abs4);
      st4_in.mag_x = abs_px[DMAG_W-1:0];
      st4_in.mag_y = abs_py[DMAG_W-1:0];
      st4_in.neg_x = st3_ff.px[DIFF_W-1];
      st4_in.neg_y = st3_ff.py[DIFF_W-1];
      st4_in.ax    = st3_ff.ax;
      st4_in.ay    = st3_ff.ay;
   end

   // Stage 5: denominator and scaled numerators
   always_comb begin
      st5_in.hit     = st4_ff.hit;
      st5_in.neg_x   = st4_ff.neg_x;
      st5_in.neg_y   = st4_ff.neg_y;
      st5_in.start_x = st4_ff.ax;
      st5_in.start_y = st4_ff.ay;
      st5_in.den     = den_type'(st4_ff.d1) + den_type'(st4_ff.d2);
      st5_in.num_x   = num_type'(st4_ff.mag_x) * num_type'(st4_ff.d1);
      st5_in.num_y   = num_type'(st4_ff.mag_y) * num_type'(st4_ff.d1);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
      end
   end

endmodule

>>> src/sip_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
// Shares the denominator between lanes; depends on sip_pkg.
module sip_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sip_pkg::div_in_type  in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sip_pkg::div_out_type out_item
);
   import sip_pkg::*;

   typedef struct packed {
      logic      hit;
      logic      neg_x;
      logic      neg_y;
      coord_type start_x;
      coord_type start_y;
      den_type   den;
      num_type   rem_x;
      num_type   rem_y;
      quo_type   quo_x;
      quo_type   quo_y;
   } stage_type;

   stage_type entry;
   stage_type stg_ff  [DIV_STAGES];
   stage_type stg_in  [DIV_STAGES];
   stage_type stg_src [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff, vld_in;
   logic      adv;

   // All stages move together unless the last item is held
   assign adv       = !vld_ff[DIV_STAGES-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign vld_in    = {vld_ff[DIV_STAGES-2:0], in_valid};

   // Entry: remainders start at the numerators
   always_comb begin
      entry.hit     = in_item.hit;
      entry.neg_x   = in_item.neg_x;
      entry.neg_y   = in_item.neg_y;
      entry.start_x = in_item.start_x;
      entry.start_y = in_item.start_y;
      entry.den     = in_item.den;
      entry.rem_x   = in_item.num_x;
      entry.rem_y   = in_item.num_y;
      entry.quo_x   = '0;
      entry.quo_y   = '0;
   end

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int SH = DIV_STAGES - 1 - j;

      if (j > 0) begin : g_link
         assign stg_src[j] = stg_ff[j-1];
      end else begin : g_entry
         assign stg_src[j] = entry;
      end

      // One quotient bit per lane: trial subtract of den shifted by SH
      always_comb begin
         num_type trial;
         logic    bit_x, bit_y;
         trial  = num_type'(stg_src[j].den) << SH;
         bit_x  = stg_src[j].rem_x >= trial;
         bit_y  = stg_src[j].rem_y >= trial;
         stg_in[j]       = stg_src[j];
         stg_in[j].rem_x = bit_x ? stg_src[j].rem_x - trial : stg_src[j].rem_x;
         stg_in[j].rem_y = bit_y ? stg_src[j].rem_y - trial : stg_src[j].rem_y;
         stg_in[j].quo_x = {stg_src[j].quo_x[QUO_W-2:0], bit_x};
         stg_in[j].quo_y = {stg_src[j].quo_y[QUO_W-2:0], bit_y};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[j] <= stg_in[j];
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Result of the last stage
   always_comb begin
      out_item.hit     = stg_ff[DIV_STAGES-1].hit;
      out_item.neg_x   = stg_ff[DIV_STAGES-1].neg_x;
      out_item.neg_y   = stg_ff[DIV_STAGES-1].neg_y;
      out_item.start_x = stg_ff[DIV_STAGES-1].start_x;
      out_item.start_y = stg_ff[DIV_STAGES-1].start_y;
      out_item.quo_x   = stg_ff[DIV_STAGES-1].quo_x;
      out_item.quo_y   = stg_ff[DIV_STAGES-1].quo_y;
   end

endmodule

>>> src/sip_back.sv
// Output stage: applies the offset sign, adds the start point, selects the
// sentinel, and buffers the result in an output register plus skid register.
// Depends on sip_pkg.
module sip_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sip_pkg::div_out_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sip_pkg::result_type  out_item
);
   import sip_pkg::*;

   result_type res_in;
   result_type out_ff, out_in;
   result_type skid_ff;
   logic       out_vld_ff, out_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   logic       accept;
   logic       out_free;

   // Crossing point, or the sentinel
   always_comb begin
      diff_type off_x, off_y;
      off_x = in_item.neg_x ? -diff_type'({1'b0, in_item.quo_x})
                            : diff_type'({1'b0, in_item.quo_x});
      off_y = in_item.neg_y ? -diff_type'({1'b0, in_item.quo_y})
                            : diff_type'({1'b0, in_item.quo_y});
      res_in.crossed = in_item.hit;
      res_in.cross_x = in_item.hit
                       ? COORD_W'(diff_type'(in_item.start_x) + off_x) : SENTINEL;
      res_in.cross_y = in_item.hit
                       ? COORD_W'(diff_type'(in_item.start_y) + off_y) : SENTINEL;
   end

   assign in_ready  = !skid_vld_ff;
   assign accept    = in_valid && in_ready;
   assign out_free  = !out_vld_ff || out_ready;
   assign out_valid = out_vld_ff;
   assign out_item  = out_ff;

   // Output register takes the skid item first, then a new item
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = res_in;
            out_vld_in = accept;
         end
      end else if (accept) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (accept && !out_free) begin
         skid_ff <= res_in;
      end
   end

endmodule

>>> src/segment_intersection_point_top.sv
// Strict crossing point of two 2D segments, signed Q12.4 coordinates.
// One item per cycle is accepted while the result side keeps up. Each item
// passes five front stages (differences, products, cross products, sides
// test, operands), sixteen divider stages giving one quotient bit each, and
// the output register. The divider is the longest part. A stall on the
// result side holds the pipeline; the output skid register lets one more
// item in while a result waits.
// Top level: depends on sip_pkg, sip_front, sip_div and sip_back.
module segment_intersection_point_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y (low to high)
   input  logic [sip_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cross_x, cross_y (low to high)
   output logic [sip_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // crossed
   output logic                            rsp_tuser
);
   import sip_pkg::*;

   seg_pair_type req_item;
   div_in_type   fr_item;
   div_out_type  dv_item;
   result_type   rs_item;
   logic         fr_valid, fr_ready;
   logic         dv_valid, dv_ready;

   // Unpack the input item
   always_comb begin
      req_item.first_start_x  = req_tdata[0*COORD_W +: COORD_W];
      req_item.first_start_y  = req_tdata[1*COORD_W +: COORD_W];
      req_item.first_end_x    = req_tdata[2*COORD_W +: COORD_W];
      req_item.first_end_y    = req_tdata[3*COORD_W +: COORD_W];
      req_item.second_start_x = req_tdata[4*COORD_W +: COORD_W];
      req_item.second_start_y = req_tdata[5*COORD_W +: COORD_W];
      req_item.second_end_x   = req_tdata[6*COORD_W +: COORD_W];
      req_item.second_end_y   = req_tdata[7*COORD_W +: COORD_W];
   end

   sip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   sip_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_item  (dv_item)
   );

   sip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_item   (dv_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rs_item)
   );

   // Pack the result item
   assign rsp_tdata = {rs_item.cross_y, rs_item.cross_x};
   assign rsp_tuser = rs_item.crossed;

endmodule

>>> src/sip_props.sv
// Port-level properties of the segment intersection block, bound to the top.
// Depends on sip_pkg and segment_intersection_point_top_assert.svh.
`include "segment_intersection_point_top_assert.svh"

module sip_props (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sip_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import sip_pkg::*;

   logic [INFLIGHT_W-1:0] inflight_ff, inflight_in;

   // Items accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_tvalid && req_tready) begin
         inflight_in = inflight_in + INFLIGHT_W'(1);
      end
      if (rsp_tvalid && rsp_tready) begin
         inflight_in = inflight_in - INFLIGHT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `SIP_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")

   `SIP_ASSERT_RST(a_rst_empty, reset, !rsp_tvalid, "result valid right after reset")

   `SIP_ASSERT_IMP(a_sentinel, rsp_tvalid && !rsp_tuser, rsp_tdata[COORD_W-1:0] == SENTINEL && rsp_tdata[RSP_DATA_W-1:COORD_W] == SENTINEL, "non-crossing item without sentinel point")

   `SIP_ASSERT_IMP(a_no_extra, rsp_tvalid && rsp_tready, inflight_ff != '0, "result item with no item in flight")

   `SIP_ASSERT_IMP(a_capacity, 1'b1, inflight_ff <= INFLIGHT_W'(PIPE_CAPACITY), "more items in flight than the pipeline holds")

endmodule

bind segment_intersection_point_top sip_props u_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
